### src/arle_pkg.sv
// ----------------------------------------------------------------------------
// arle_pkg
// Shared constants, width helpers and the result bundle type of the
// alternating run-length encoder.
// ----------------------------------------------------------------------------
package arle_pkg;

   // default bound on the source block length in bytes
   localparam int ARLE_MAX_BYTES = 1048576;

   // widths of the output offset and size fields
   localparam int OUT_OFF_W = 21;

   // one input element causes at most this many byte writes
   localparam int MAX_RESULTS = 4;
   localparam int RES_IDX_W   = 2;
   localparam int RES_CNT_W   = 3;

   // a segment count of this value continues the segment
   localparam logic [7:0] COUNT_FULL = 8'd255;

   // byte writes caused by one element, plus end-of-block status
   typedef struct packed {
      logic [RES_CNT_W-1:0]                  count;
      logic [MAX_RESULTS-1:0][OUT_OFF_W-1:0] offset;
      logic [MAX_RESULTS-1:0][7:0]           data;
      logic                                  done;
      logic [OUT_OFF_W-1:0]                  total;
      logic                                  ovf;
   } arle_bundle_type;

   // internal offset width: covers the worst-case encoded size of a block
   // that stays within max_bytes, and never below the port width
   function automatic int off_width(int max_bytes);
      int w;
      w = $clog2(4 * max_bytes + 8);
      return (w > OUT_OFF_W) ? w : OUT_OFF_W;
   endfunction

   // source byte counter width: holds max_bytes + 1 (saturation point)
   function automatic int src_width(int max_bytes);
      return $clog2(max_bytes + 2);
   endfunction

endpackage

### src/alternating_rle_encoder.sv
// ----------------------------------------------------------------------------
// alternating_rle_encoder
// Streaming run-length encoder with alternating literal and run segments;
// each element yields zero to four byte writes at buffer offsets.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/ready    req_element, req_final_element
//  rsp      out        rsp_valid/ready    offset, byte, item_last, done, size, ovf
//  csr      in         csr_wr_en          csr_wr_data (element_wide)
//
//  An element is encoded in the cycle it is accepted; its writes sit in a
//  result register and leave one byte per cycle while rsp is ready, so the
//  one-byte result port sets the pace of elements that cause writes.
//  A new element is taken as the last write of the previous one leaves.
//  Synchronous active-high reset clears the block state and the count and
//  index of the result register; a stalled rsp holds its write, blocks req.
// ----------------------------------------------------------------------------
module alternating_rle_encoder
   import arle_pkg::*;
#(
   parameter int MAX_BYTES = ARLE_MAX_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [15:0]          req_element,
   input  logic                 req_final_element,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_OFF_W-1:0] rsp_out_offset,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_item_last,
   output logic                 rsp_block_done,
   output logic [OUT_OFF_W-1:0] rsp_total_size,
   output logic                 rsp_overflow
);

   localparam int OW = off_width(MAX_BYTES);
   localparam int SW = src_width(MAX_BYTES);

   logic                 element_wide_ff;
   logic                 in_run_ff,       in_run_in;
   logic [15:0]          prev_element_ff, prev_element_in;
   logic                 have_prev_ff,    have_prev_in;
   logic [7:0]           seg_count_ff,    seg_count_in;
   logic [OW-1:0]        hdr_offset_ff,   hdr_offset_in;
   logic [OW-1:0]        wr_offset_ff,    wr_offset_in;
   logic [SW-1:0]        src_bytes_ff,    src_bytes_in;
   arle_bundle_type      bundle_ff,       bundle_in;
   logic [RES_CNT_W-1:0] pending_ff;
   logic [RES_IDX_W-1:0] idx_ff;
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 rsp_last;

   // encoder step
   arle_step #(
      .MAX_BYTES (MAX_BYTES),
      .OW        (OW),
      .SW        (SW)
   ) u_step (
      .wide            (element_wide_ff),
      .element         (req_element),
      .final_element   (req_final_element),
      .in_run          (in_run_ff),
      .prev_element    (prev_element_ff),
      .have_prev       (have_prev_ff),
      .seg_count       (seg_count_ff),
      .hdr_offset      (hdr_offset_ff),
      .wr_offset       (wr_offset_ff),
      .src_bytes       (src_bytes_ff),
      .in_run_nx       (in_run_in),
      .prev_element_nx (prev_element_in),
      .have_prev_nx    (have_prev_in),
      .seg_count_nx    (seg_count_in),
      .hdr_offset_nx   (hdr_offset_in),
      .wr_offset_nx    (wr_offset_in),
      .src_bytes_nx    (src_bytes_in),
      .bundle          (bundle_in)
   );

   // handshake
   assign rsp_valid = (pending_ff != '0);
   assign rsp_last  = ({1'b0, idx_ff} == (pending_ff - RES_CNT_W'(1)));
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = !rsp_valid || (rsp_fire && rsp_last);
   assign req_fire  = req_valid && req_ready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         element_wide_ff <= 1'b0;
      end else if (csr_wr_en) begin
         element_wide_ff <= csr_wr_data;
      end
   end

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff       <= 1'b0;
         prev_element_ff <= '0;
         have_prev_ff    <= 1'b0;
         seg_count_ff    <= '0;
         hdr_offset_ff   <= '0;
         wr_offset_ff    <= '0;
         src_bytes_ff    <= '0;
      end else if (req_fire) begin
         in_run_ff       <= in_run_in;
         prev_element_ff <= prev_element_in;
         have_prev_ff    <= have_prev_in;
         seg_count_ff    <= seg_count_in;
         hdr_offset_ff   <= hdr_offset_in;
         wr_offset_ff    <= wr_offset_in;
         src_bytes_ff    <= src_bytes_in;
      end
   end

   // result register: pending count and read index
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         idx_ff     <= '0;
      end else if (req_fire) begin
         pending_ff <= bundle_in.count;
         idx_ff     <= '0;
      end else if (rsp_fire) begin
         if (rsp_last) begin
            pending_ff <= '0;
         end else begin
            idx_ff <= idx_ff + RES_IDX_W'(1);
         end
      end
   end

   // result register: payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         bundle_ff <= bundle_in;
      end
   end

   // current write
   assign rsp_out_offset = bundle_ff.offset[idx_ff];
   assign rsp_out_byte   = bundle_ff.data[idx_ff];
   assign rsp_item_last  = rsp_last;
   assign rsp_block_done = bundle_ff.done && rsp_last;
   assign rsp_total_size = rsp_block_done ? bundle_ff.total : '0;
   assign rsp_overflow   = rsp_block_done && bundle_ff.ovf;

endmodule

### src/arle_step.sv
// ----------------------------------------------------------------------------
// arle_step
// Encoder step: from the block state and one element, the byte writes that
// the element causes and the next block state.
// ----------------------------------------------------------------------------
module arle_step
   import arle_pkg::*;
#(
   parameter int MAX_BYTES = ARLE_MAX_BYTES,
   parameter int OW        = off_width(MAX_BYTES),
   parameter int SW        = src_width(MAX_BYTES)
) (
   input  logic                  wide,
   input  logic [15:0]           element,
   input  logic                  final_element,
   input  logic                  in_run,
   input  logic [15:0]           prev_element,
   input  logic                  have_prev,
   input  logic [7:0]            seg_count,
   input  logic [OW-1:0]         hdr_offset,
   input  logic [OW-1:0]         wr_offset,
   input  logic [SW-1:0]         src_bytes,
   output logic                  in_run_nx,
   output logic [15:0]           prev_element_nx,
   output logic                  have_prev_nx,
   output logic [7:0]            seg_count_nx,
   output logic [OW-1:0]         hdr_offset_nx,
   output logic [OW-1:0]         wr_offset_nx,
   output logic [SW-1:0]         src_bytes_nx,
   output arle_bundle_type       bundle
);

   localparam logic [SW:0] SRC_SAT = (SW+1)'(MAX_BYTES + 1);

   logic [15:0]          e;
   logic                 same;
   logic [SW:0]          src_sum;
   logic [SW-1:0]        src_n;
   logic                 run;
   logic [7:0]           cnt;
   logic [OW-1:0]        hdr;
   logic [OW-1:0]        wr;
   logic [RES_CNT_W-1:0] n;

   // masked element and match against the stored one
   assign e    = wide ? element : {8'h00, element[7:0]};
   assign same = (e == prev_element);

   // source byte count, saturating just above the limit
   always_comb begin
      src_sum = {1'b0, src_bytes} + (wide ? (SW+1)'(2) : (SW+1)'(1));
      src_n   = (src_sum > SRC_SAT) ? SRC_SAT[SW-1:0] : src_sum[SW-1:0];
   end

   // segment logic, one write slot after another
   always_comb begin
      bundle = '0;
      n      = '0;
      run    = in_run;
      cnt    = seg_count;
      hdr    = hdr_offset;
      wr     = wr_offset;

      // literal followed by a repeat: close the literal, open a run
      if (have_prev && !in_run && same) begin
         bundle.offset[n[RES_IDX_W-1:0]] = hdr[OUT_OFF_W-1:0];
         bundle.data[n[RES_IDX_W-1:0]]   = cnt;
         n   = n + RES_CNT_W'(1);
         run = 1'b1;
         cnt = 8'd1;
      end

      // run continues; a full count is flushed at once
      if (have_prev && in_run && same) begin
         cnt = cnt + 8'd1;
         if (cnt == COUNT_FULL) begin
            bundle.offset[n[RES_IDX_W-1:0]] = wr[OUT_OFF_W-1:0];
            bundle.data[n[RES_IDX_W-1:0]]   = COUNT_FULL;
            n   = n + RES_CNT_W'(1);
            wr  = wr + OW'(1);
            cnt = 8'd0;
         end
      end

      // run broken: write its remainder
      if (have_prev && in_run && !same) begin
         bundle.offset[n[RES_IDX_W-1:0]] = wr[OUT_OFF_W-1:0];
         bundle.data[n[RES_IDX_W-1:0]]   = cnt;
         n  = n + RES_CNT_W'(1);
         wr = wr + OW'(1);
      end

      // open a literal segment: reserve its count slot
      if (!have_prev || (in_run && !same)) begin
         run = 1'b0;
         hdr = wr;
         wr  = wr + OW'(1);
         cnt = 8'd0;
      end

      // append a literal element, low byte first
      if (!have_prev || !same) begin
         bundle.offset[n[RES_IDX_W-1:0]] = wr[OUT_OFF_W-1:0];
         bundle.data[n[RES_IDX_W-1:0]]   = e[7:0];
         n  = n + RES_CNT_W'(1);
         wr = wr + OW'(1);
         if (wide) begin
            bundle.offset[n[RES_IDX_W-1:0]] = wr[OUT_OFF_W-1:0];
            bundle.data[n[RES_IDX_W-1:0]]   = e[15:8];
            n  = n + RES_CNT_W'(1);
            wr = wr + OW'(1);
         end
         cnt = cnt + 8'd1;
         // full literal: fill its slot, reserve the next one
         if (cnt == COUNT_FULL) begin
            bundle.offset[n[RES_IDX_W-1:0]] = hdr[OUT_OFF_W-1:0];
            bundle.data[n[RES_IDX_W-1:0]]   = COUNT_FULL;
            n   = n + RES_CNT_W'(1);
            hdr = wr;
            wr  = wr + OW'(1);
            cnt = 8'd0;
         end
      end

      // end of block: close the open segment and report status
      if (final_element) begin
         if (run) begin
            bundle.offset[n[RES_IDX_W-1:0]] = wr[OUT_OFF_W-1:0];
            bundle.data[n[RES_IDX_W-1:0]]   = cnt;
            wr = wr + OW'(1);
         end else begin
            bundle.offset[n[RES_IDX_W-1:0]] = hdr[OUT_OFF_W-1:0];
            bundle.data[n[RES_IDX_W-1:0]]   = cnt;
         end
         n            = n + RES_CNT_W'(1);
         bundle.done  = 1'b1;
         bundle.total = wr[OUT_OFF_W-1:0];
         bundle.ovf   = (src_n > SW'(MAX_BYTES)) ||
                        (wr >= {{(OW-SW){1'b0}}, src_n});
      end

      bundle.count = n;
   end

   // next block state; a final element returns it to zero
   always_comb begin
      if (final_element) begin
         in_run_nx       = 1'b0;
         prev_element_nx = '0;
         have_prev_nx    = 1'b0;
         seg_count_nx    = '0;
         hdr_offset_nx   = '0;
         wr_offset_nx    = '0;
         src_bytes_nx    = '0;
      end else begin
         in_run_nx       = run;
         prev_element_nx = e;
         have_prev_nx    = 1'b1;
         seg_count_nx    = cnt;
         hdr_offset_nx   = hdr;
         wr_offset_nx    = wr;
         src_bytes_nx    = src_n;
      end
   end

endmodule

### src/arle_checker.sv
// ----------------------------------------------------------------------------
// arle_checker
// Port-level checks of the alternating run-length encoder, bound to the top.
// ----------------------------------------------------------------------------
module arle_checker
   import arle_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUT_OFF_W-1:0] rsp_out_offset,
   input logic [7:0]           rsp_out_byte,
   input logic                 rsp_item_last,
   input logic                 rsp_block_done,
   input logic [OUT_OFF_W-1:0] rsp_total_size,
   input logic                 rsp_overflow
);

   // no writes left over after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // block end is always the last write of its element
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_done) |-> rsp_item_last)
      else $error("block_done without item_last");

   // status fields are zero away from block end
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_block_done) |-> (rsp_total_size == '0 && !rsp_overflow))
      else $error("status fields set before block end");

   // a stalled write holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_offset) && $stable(rsp_out_byte)))
      else $error("stalled write changed");

   // input is taken only when the last write of the element leaves
   a_req_gate: assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid) |-> (rsp_ready && rsp_item_last))
      else $error("input taken while writes remain");

endmodule

bind alternating_rle_encoder arle_checker u_arle_checker (.*);
